### rtl/core/ps2ht_pkg.sv
`default_nettype none

package ps2ht_pkg;

   // timing register widths and reset values
   localparam int unsigned TICK_W = 16;
   localparam logic [TICK_W-1:0] INHIBIT_RESET = 16'd5000;
   localparam logic [TICK_W-1:0] HOLD_RESET    = 16'd500;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INHIBIT_TICKS    = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_HOLD_TICKS = 8'd1;

   // stream widths
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // frame bit counter limits
   localparam logic [3:0] DATA_BITS = 4'd8;
   localparam logic [3:0] PARITY_POS = 4'd9;
   localparam logic [3:0] STOP_POS   = 4'd10;

   typedef enum logic [3:0] {
      PH_RX_START   = 4'd0,
      PH_RX_DATA    = 4'd1,
      PH_RX_PARITY  = 4'd2,
      PH_RX_STOP    = 4'd3,
      PH_RX_END     = 4'd4,
      PH_TX_INHIBIT = 4'd5,
      PH_TX_HOLD    = 4'd6,
      PH_TX_BITS    = 4'd7,
      PH_TX_STOP    = 4'd8,
      PH_TX_ACKDATA = 4'd9,
      PH_TX_ACKCLK  = 4'd10,
      PH_TX_RELEASE = 4'd11
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] inhibit_ticks;
      logic [TICK_W-1:0] start_hold_ticks;
   } cfg_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] tx_byte;
      logic       clk_line;
      logic       data_line;
   } item_type;

   typedef struct packed {
      logic       busy_sending;
      logic       tx_done;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       data_drive_low;
      logic       clk_drive_low;
   } result_type;

endpackage

`default_nettype wire

### rtl/core/ps2ht_csr.sv
`default_nettype none

module ps2ht_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ps2ht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ps2ht_pkg::TICK_W-1:0]      csr_data,
   output ps2ht_pkg::cfg_type                     cfg
);
   import ps2ht_pkg::*;

   logic [TICK_W-1:0] inhibit_ff;
   logic [TICK_W-1:0] hold_ff;

   assign csr_ready = 1'b1;

   // writes to unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         inhibit_ff <= INHIBIT_RESET;
         hold_ff    <= HOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INHIBIT_TICKS:    inhibit_ff <= csr_data;
            CSR_START_HOLD_TICKS: hold_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.inhibit_ticks    = inhibit_ff;
   assign cfg.start_hold_ticks = hold_ff;

endmodule

`default_nettype wire

### rtl/core/ps2ht_core.sv
`default_nettype none

module ps2ht_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire ps2ht_pkg::item_type   item,
   input  wire ps2ht_pkg::cfg_type    cfg,
   output ps2ht_pkg::result_type      result
);
   import ps2ht_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [3:0]        bit_index_ff, bit_index_in;
   logic [7:0]        shift_ff, shift_in;
   logic              parity_ff, parity_in;
   logic [TICK_W-1:0] timer_ff, timer_in;
   logic              last_clk_ff;
   logic [7:0]        held_rx_ff, held_rx_in;
   logic              rx_valid, tx_done;

   logic              fall;
   logic [3:0]        bit_next;
   logic [TICK_W-1:0] timer_inc;

   // data level driven during the bit phase, 1 pulls the line low
   function automatic logic tx_data_low(input logic [3:0] bi, input logic [7:0] sr,
                                        input logic par);
      logic [2:0] idx;
      logic       low;
      idx = 3'(bi - 4'd1);
      if (bi == 4'd0)
         low = 1'b1;
      else if (bi inside {[4'd1:DATA_BITS]})
         low = ~sr[idx];
      else if (bi == PARITY_POS)
         low = ~par;
      else
         low = 1'b0;
      return low;
   endfunction

   assign fall      = last_clk_ff & ~item.clk_line;
   assign bit_next  = bit_index_ff + 4'd1;
   assign timer_inc = (timer_ff != '1) ? timer_ff + 1'b1 : timer_ff;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      bit_index_in = bit_index_ff;
      shift_in     = shift_ff;
      parity_in    = parity_ff;
      timer_in     = timer_ff;
      held_rx_in   = held_rx_ff;
      rx_valid     = 1'b0;
      tx_done      = 1'b0;
      if (item.operation && (phase_ff inside {PH_RX_START, PH_RX_DATA, PH_RX_PARITY,
                                              PH_RX_STOP, PH_RX_END})) begin
         // host wins over a partial incoming frame
         phase_in     = PH_TX_INHIBIT;
         timer_in     = '0;
         shift_in     = item.tx_byte;
         parity_in    = 1'b1;
         bit_index_in = '0;
      end else begin
         case (phase_ff)
            PH_RX_DATA: begin
               if (fall) begin
                  shift_in     = {item.data_line, shift_ff[7:1]};
                  bit_index_in = bit_next;
                  if (bit_next >= DATA_BITS) phase_in = PH_RX_PARITY;
               end
            end
            PH_RX_PARITY: if (fall) phase_in = PH_RX_STOP;
            PH_RX_STOP:   if (fall) phase_in = PH_RX_END;
            PH_RX_END: begin
               if (item.clk_line) begin
                  held_rx_in = shift_ff;
                  rx_valid   = 1'b1;
                  phase_in   = PH_RX_START;
               end
            end
            PH_TX_INHIBIT: begin
               timer_in = timer_inc;
               if (timer_inc >= cfg.inhibit_ticks) begin
                  phase_in = PH_TX_HOLD;
                  timer_in = '0;
               end
            end
            PH_TX_HOLD: begin
               timer_in = timer_inc;
               if (timer_inc >= cfg.start_hold_ticks) begin
                  phase_in     = PH_TX_BITS;
                  timer_in     = '0;
                  bit_index_in = '0;
               end
            end
            PH_TX_BITS: begin
               if (fall) begin
                  bit_index_in = bit_next;
                  if (bit_next <= DATA_BITS)
                     parity_in = parity_ff ^ shift_ff[3'(bit_next - 4'd1)];
                  else if (bit_next >= STOP_POS)
                     phase_in = PH_TX_STOP;
               end
            end
            PH_TX_STOP:    if (item.clk_line) phase_in = PH_TX_ACKDATA;
            PH_TX_ACKDATA: if (!item.data_line) phase_in = PH_TX_ACKCLK;
            PH_TX_ACKCLK:  if (!item.clk_line) phase_in = PH_TX_RELEASE;
            PH_TX_RELEASE: begin
               if (item.clk_line && item.data_line) begin
                  tx_done  = 1'b1;
                  phase_in = PH_RX_START;
               end
            end
            default: begin
               // wait for start bit
               if (fall) begin
                  phase_in     = PH_RX_DATA;
                  bit_index_in = '0;
                  shift_in     = '0;
               end
            end
         endcase
      end
   end

   // line drives follow the updated phase
   always_comb begin
      result.clk_drive_low  = 1'b0;
      result.data_drive_low = 1'b0;
      case (phase_in)
         PH_TX_INHIBIT: result.clk_drive_low = 1'b1;
         PH_TX_HOLD: begin
            result.clk_drive_low  = 1'b1;
            result.data_drive_low = 1'b1;
         end
         PH_TX_BITS: result.data_drive_low = tx_data_low(bit_index_in, shift_in, parity_in);
         default: ;
      endcase
      result.rx_byte      = held_rx_in;
      result.rx_valid     = rx_valid;
      result.tx_done      = tx_done;
      result.busy_sending = (phase_in >= PH_TX_INHIBIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RX_START;
         bit_index_ff <= '0;
         shift_ff     <= '0;
         parity_ff    <= 1'b1;
         timer_ff     <= '0;
         last_clk_ff  <= 1'b1;
         held_rx_ff   <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_index_ff <= bit_index_in;
         shift_ff     <= shift_in;
         parity_ff    <= parity_in;
         timer_ff     <= timer_in;
         last_clk_ff  <= item.clk_line;
         held_rx_ff   <= held_rx_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ps2_host_transceiver.sv
// a result passes the input register and then the result register on its way out;
//    the port state advances as the item leaves the input register
// throughput: one sample tick per cycle, as long as the result side does not stall
// reset: synchronous, active high; timing registers return to 5000 and 500 ticks,
//    the port returns to waiting for a start bit with no byte held
`default_nettype none

module ps2_host_transceiver (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ps2ht_pkg::REQ_DATA_W-1:0]  req_tdata,  // tx_byte, clk_line, data_line
   input  wire logic                              req_tuser,  // operation
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // clk_drive_low, data_drive_low, rx_byte, rx_valid, tx_done, busy_sending
   output logic [ps2ht_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ps2ht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ps2ht_pkg::TICK_W-1:0]      csr_data
);
   import ps2ht_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       advance;

   // item moves from input register to result register when the latter frees up
   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   // unpack request transfer
   assign item_in.operation = req_tuser;
   assign item_in.tx_byte   = req_tdata[7:0];
   assign item_in.clk_line  = req_tdata[8];
   assign item_in.data_line = req_tdata[9];

   ps2ht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // port state machine, stepped once per item
   ps2ht_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   // pack result, first field in bit 0, zero fill to 16 bits
   assign rsp_tdata  = {3'b000, rsp_ff.busy_sending, rsp_ff.tx_done, rsp_ff.rx_valid,
                        rsp_ff.rx_byte, rsp_ff.data_drive_low, rsp_ff.clk_drive_low};

endmodule

`default_nettype wire

### dv/ps2ht_checker.sv
`timescale 1ns / 1ps

module ps2ht_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [ps2ht_pkg::REQ_DATA_W-1:0]  req_tdata,  // tx_byte, clk_line, data_line
   input  wire logic                              req_tuser,  // operation
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // clk_drive_low, data_drive_low, rx_byte, rx_valid, tx_done, busy_sending
   input  wire logic [ps2ht_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [ps2ht_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ps2ht_pkg::TICK_W-1:0]      csr_data,
   output int unsigned                            error_count,
   output int unsigned                            pending
);
   import ps2ht_pkg::*;

   // shadow of the port state
   logic [TICK_W-1:0] inhibit_reg;
   logic [TICK_W-1:0] hold_reg;
   logic [TICK_W-1:0] timer_q;
   phase_type         port_phase;
   logic [3:0]        bit_cnt;
   logic [7:0]        frame_q;
   logic [7:0]        held_rx_q;
   logic              parity_q;
   logic              last_clk_q;

   result_type  line_results[$];
   int unsigned n_in;
   int unsigned n_out;

   assign pending = n_in - n_out;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch, %s", $time, what);
      error_count++;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         report_mismatch($sformatf("result %0d %s expected %0h got %0h",
                                   n_out, name, want, got));
      end
   endtask

   // one sample tick of the host port, returns the line drives and status after it
   function automatic result_type advance_port(input item_type smp);
      logic       fall;
      result_type r;
      fall = last_clk_q & ~smp.clk_line;
      r = '0;
      if (port_phase > PH_TX_RELEASE) port_phase = PH_RX_START;
      if (smp.operation && port_phase < PH_TX_INHIBIT) begin
         // host has priority, a partial frame is dropped
         port_phase = PH_TX_INHIBIT;
         timer_q = '0;
         frame_q = smp.tx_byte;
         parity_q = 1'b1;
         bit_cnt = '0;
      end else begin
         case (port_phase)
            PH_RX_START: if (fall) begin
               port_phase = PH_RX_DATA;
               bit_cnt = '0;
               frame_q = '0;
            end
            PH_RX_DATA: if (fall) begin
               frame_q = {smp.data_line, frame_q[7:1]};
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= DATA_BITS) port_phase = PH_RX_PARITY;
            end
            PH_RX_PARITY: if (fall) port_phase = PH_RX_STOP;
            PH_RX_STOP: if (fall) port_phase = PH_RX_END;
            PH_RX_END: if (smp.clk_line) begin
               held_rx_q = frame_q;
               r.rx_valid = 1'b1;
               port_phase = PH_RX_START;
            end
            PH_TX_INHIBIT: begin
               if (timer_q != '1) timer_q = timer_q + 1'b1;
               if (timer_q >= inhibit_reg) begin
                  port_phase = PH_TX_HOLD;
                  timer_q = '0;
               end
            end
            PH_TX_HOLD: begin
               if (timer_q != '1) timer_q = timer_q + 1'b1;
               if (timer_q >= hold_reg) begin
                  port_phase = PH_TX_BITS;
                  timer_q = '0;
                  bit_cnt = '0;
               end
            end
            PH_TX_BITS: if (fall) begin
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt <= DATA_BITS) parity_q = parity_q ^ frame_q[bit_cnt - 4'd1];
               else if (bit_cnt >= STOP_POS) port_phase = PH_TX_STOP;
            end
            PH_TX_STOP: if (smp.clk_line) port_phase = PH_TX_ACKDATA;
            PH_TX_ACKDATA: if (!smp.data_line) port_phase = PH_TX_ACKCLK;
            PH_TX_ACKCLK: if (!smp.clk_line) port_phase = PH_TX_RELEASE;
            default: if (smp.clk_line && smp.data_line) begin
               r.tx_done = 1'b1;
               port_phase = PH_RX_START;
            end
         endcase
      end
      last_clk_q = smp.clk_line;

      case (port_phase)
         PH_TX_INHIBIT: r.clk_drive_low = 1'b1;
         PH_TX_HOLD: begin
            r.clk_drive_low = 1'b1;
            r.data_drive_low = 1'b1;
         end
         PH_TX_BITS: begin
            if (bit_cnt == 4'd0) r.data_drive_low = 1'b1;  // start bit
            else if (bit_cnt <= DATA_BITS) r.data_drive_low = ~frame_q[bit_cnt - 4'd1];
            else if (bit_cnt == PARITY_POS) r.data_drive_low = ~parity_q;
         end
         default: ;
      endcase
      r.rx_byte = held_rx_q;
      r.busy_sending = (port_phase >= PH_TX_INHIBIT);
      return r;
   endfunction

   always @(posedge clock) begin : watch_ports
      item_type   smp;
      result_type want;
      if (reset) begin
         inhibit_reg = INHIBIT_RESET;
         hold_reg = HOLD_RESET;
         timer_q = '0;
         port_phase = PH_RX_START;
         bit_cnt = '0;
         frame_q = '0;
         held_rx_q = '0;
         parity_q = 1'b1;
         last_clk_q = 1'b1;
         line_results.delete();
         n_in = 0;
         n_out = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INHIBIT_TICKS:    inhibit_reg = csr_data;
               CSR_START_HOLD_TICKS: hold_reg = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            smp.operation = req_tuser;
            smp.tx_byte = req_tdata[7:0];
            smp.clk_line = req_tdata[8];
            smp.data_line = req_tdata[9];
            line_results.push_back(advance_port(smp));
            n_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (line_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = line_results.pop_front();
               compare_field("clk_drive_low", want.clk_drive_low, rsp_tdata[0]);
               compare_field("data_drive_low", want.data_drive_low, rsp_tdata[1]);
               compare_field("rx_byte", want.rx_byte, rsp_tdata[9:2]);
               compare_field("rx_valid", want.rx_valid, rsp_tdata[10]);
               compare_field("tx_done", want.tx_done, rsp_tdata[11]);
               compare_field("busy_sending", want.busy_sending, rsp_tdata[12]);
               compare_field("padding", 0, rsp_tdata[RSP_DATA_W-1:13]);
               n_out++;
            end
         end
      end
   end

endmodule

### dv/tb_ps2_host_transceiver.sv
`timescale 1ns / 1ps

module tb_ps2_host_transceiver;
   import ps2ht_pkg::*;

   // receiver stall styles
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_PATTERN,
      READY_SPARSE
   } ready_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // tx_byte, clk_line, data_line
   logic                   req_tuser = 1'b0; // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // clk_drive_low, data_drive_low, rx_byte, rx_valid, tx_done, busy_sending
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TICK_W-1:0]      csr_data = '0;

   int unsigned error_count;
   int unsigned pending;

   // sender burst state and a running count of sample ticks handed over
   int          burst_left = 0;
   int unsigned tick_total = 0;

   // timing values last written, the device model needs them to pace a send
   logic [TICK_W-1:0] cur_inhibit = INHIBIT_RESET;
   logic [TICK_W-1:0] cur_hold = HOLD_RESET;

   // receiver stall pattern
   ready_style_type ready_style = READY_ALWAYS;
   int              ready_left = 0;
   logic [7:0]      ready_mask = 8'h01;

   ps2_host_transceiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ps2ht_checker i_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (error_count),
      .pending     (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side stalls, style changes every stretch of cycles
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_style = ready_style_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 160);
         ready_mask = 8'($urandom) | 8'h01;
      end
      ready_left--;
      case (ready_style)
         READY_ALWAYS: rsp_tready = 1'b1;
         READY_MOSTLY: rsp_tready = ($urandom_range(0, 3) != 0);
         READY_PATTERN: begin
            rsp_tready = ready_mask[0];
            ready_mask = {ready_mask[0], ready_mask[7:1]};
         end
         default: rsp_tready = ($urandom_range(0, 3) == 0);
      endcase
   end

   // a zero timing value behaves as one tick
   function automatic int span(input logic [TICK_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   // random byte with the two extremes weighted up
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // hand one sample tick over, bursts with random gaps between them
   task automatic put_tick(input logic op, input logic [7:0] value,
                           input logic cl, input logic dl);
      int idle;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (idle != 0) begin
            req_tvalid = 1'b0;
            repeat (idle) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {6'b0, dl, cl, value};
      do @(posedge clock); while (!req_tready);
      tick_total++;
   endtask

   // both lines released
   task automatic line_idle(input int n);
      repeat (n) put_tick(1'b0, 8'($urandom), 1'b1, 1'b1);
   endtask

   // one device clock pulse, data held across it, falling edge on the first low tick
   task automatic clock_pulse(input logic dl, input bit echo_req);
      repeat ($urandom_range(1, 2)) begin
         put_tick(echo_req && $urandom_range(0, 7) == 0, pick_byte(), 1'b1, dl);
      end
      repeat ($urandom_range(1, 2)) begin
         put_tick(echo_req && $urandom_range(0, 7) == 0, pick_byte(), 1'b0, dl);
      end
   endtask

   // device to host frame, nbits below 11 cuts it short
   task automatic device_frame(input logic [7:0] value, input int nbits, input bit bad_parity);
      logic [10:0] frame_bits;
      frame_bits = {1'b1, ~^value ^ bad_parity, value, 1'b0};  // stop, parity, data, start
      for (int i = 0; i < nbits; i++) clock_pulse(frame_bits[i], 1'b0);
   endtask

   // host to device send as the device sees it, fewer than 10 pulses leaves it hanging
   task automatic host_send(input logic [7:0] value, input bit echo_req, input int pulses);
      logic [10:0] frame_bits;
      int          inhibit_span;
      int          waits;
      frame_bits = {1'b1, ~^value, value, 1'b0};
      inhibit_span = span(cur_inhibit);
      waits = inhibit_span + span(cur_hold);
      put_tick(1'b1, value, 1'b1, 1'b1);
      // clock held low by the host, requests here must be ignored
      for (int i = 0; i < waits; i++) begin
         put_tick(echo_req && $urandom_range(0, 15) == 0, pick_byte(), 1'b0,
                  (i >= inhibit_span) ? 1'b0 : 1'($urandom));
      end
      for (int k = 1; k <= pulses; k++) clock_pulse(frame_bits[k], echo_req);
      if (pulses >= 10) begin
         // stop released, device acknowledge, then both lines back high
         repeat ($urandom_range(1, 2)) put_tick(1'b0, pick_byte(), 1'b1, 1'b1);
         repeat ($urandom_range(1, 2)) put_tick(1'b0, pick_byte(), 1'b1, 1'b0);
         repeat ($urandom_range(1, 2)) put_tick(1'b0, pick_byte(), 1'b0, 1'b0);
         put_tick(1'b0, pick_byte(), 1'b1, 1'b1);
      end
   endtask

   // random line levels with the odd send request mixed in
   task automatic line_noise(input int n);
      repeat (n) begin
         put_tick($urandom_range(0, 15) == 0, pick_byte(), 1'($urandom), 1'($urandom));
      end
   endtask

   // stop sending until every expected result has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // both timing registers, written back to back while the port is quiet
   task automatic set_timing(input logic [TICK_W-1:0] inh, input logic [TICK_W-1:0] hold);
      drain();
      for (int r = 0; r < 2; r++) begin
         @(negedge clock);
         csr_valid = 1'b1;
         csr_index = (r == 0) ? CSR_INHIBIT_TICKS : CSR_START_HOLD_TICKS;
         csr_data = (r == 0) ? inh : hold;
         do @(posedge clock); while (!csr_ready);
      end
      @(negedge clock);
      csr_valid = 1'b0;
      cur_inhibit = inh;
      cur_hold = hold;
   endtask

   initial begin
      int unsigned phase_start;
      int          seqs;
      int          pick;
      int          wait_cycles;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // frames at the byte extremes and one with bad parity, parity left unchecked
      device_frame(8'h00, 11, 1'b0);
      line_idle(2);
      device_frame(8'hFF, 11, 1'b0);
      line_idle(1);
      device_frame(8'hA5, 11, 1'b1);
      line_idle(2);

      // zero timing values act as one tick
      set_timing('0, '0);
      host_send(8'h00, 1'b0, 10);
      line_idle(1);
      host_send(8'hFF, 1'b1, 10);
      line_idle(1);
      // request in the middle of a device frame, host wins
      device_frame(8'h3C, 6, 1'b0);
      host_send(8'h81, 1'b0, 10);
      line_idle(2);
      line_noise(16);
      line_idle(3);

      set_timing(16'd1, 16'd1);
      device_frame(8'h7E, 11, 1'b0);
      // request right on the completing tick drops the finished frame
      host_send(8'h01, 1'b0, 10);
      line_idle(2);

      // random part: mostly well-formed frames and sends, some cut short or noisy
      for (int p = 0; p < 2; p++) begin
         set_timing(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
         phase_start = tick_total;
         seqs = 0;
         while (tick_total - phase_start < 50 || seqs < 2) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               device_frame(pick_byte(), 11, $urandom_range(0, 7) == 0);
            end else if (pick < 70) begin
               host_send(pick_byte(), 1'($urandom), 10);
            end else if (pick < 80) begin
               device_frame(pick_byte(), $urandom_range(1, 10), 1'b0);
               host_send(pick_byte(), 1'b0, 10);
            end else if (pick < 88) begin
               device_frame(pick_byte(), $urandom_range(1, 10), 1'b0);
            end else if (pick < 94) begin
               line_noise($urandom_range(1, 20));
            end else begin
               host_send(pick_byte(), 1'b1, $urandom_range(1, 9));
            end
            line_idle($urandom_range(0, 4));
            // now and then let the result side catch up completely
            if ($urandom_range(0, 29) == 0) drain();
            seqs++;
         end
      end

      // wait out the results still in flight, bounded
      @(negedge clock);
      req_tvalid = 1'b0;
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 5000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(negedge clock);

      if (error_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### ps2_host_transceiver.f
rtl/core/ps2ht_pkg.sv
rtl/core/ps2ht_csr.sv
rtl/core/ps2ht_core.sv
rtl/core/ps2_host_transceiver.sv
dv/ps2ht_checker.sv
dv/tb_ps2_host_transceiver.sv
